/* design/clt_pkg.sv */
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Shared codes, the operation word that passes from the front to the back,
// and the result word that leaves the block.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Operation kinds handed from the classifier to the executor.
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_BUF_LIMIT = 1'b0;
    localparam logic CFG_MAX_ARGS  = 1'b1;

    localparam logic [10:0] BUF_LIMIT_RESET = 11'd1024;
    localparam logic [7:0]  MAX_ARGS_RESET  = 8'd128;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_val;
    } t_op;

    typedef struct packed {
        logic       write_valid;
        logic [9:0] write_addr;
        logic [7:0] write_byte;
        logic       arg_valid;
        logic [6:0] arg_index;
        logic [9:0] arg_start;
        logic       done_res;
        logic [7:0] arg_total;
        logic       error;
    } t_result;

endpackage

/* design/command_line_tokenizer.sv */
// A character word is held in the operation queue, and its result in the result queue, before it can be popped.
// Throughput: one character per cycle while neither queue is full; the executor forms each result combinationally.
// The classifier and executor each stall on their own through two-entry queues.
// Reset is synchronous and active low; it clears quote mode, positions, count and error,
// and returns buffer_limit to 1024 and max_args to 128.
// ----------------------------------------------------------------------------
// Command line tokenizer
// Splits a command line into arguments with double-quote grouping and reports
// every buffer write, every completed argument and the final count.
// ----------------------------------------------------------------------------
module command_line_tokenizer #(
    parameter int BUF_DEPTH = 1024,
    parameter int MAX_ARGS  = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_line,
    output logic        empty,
    input  logic        pop,
    output logic        o_write_valid,
    output logic [9:0]  o_write_addr,
    output logic [7:0]  o_write_byte,
    output logic        o_arg_valid,
    output logic [6:0]  o_arg_index,
    output logic [9:0]  o_arg_start,
    output logic        o_done_res,
    output logic [7:0]  o_arg_total,
    output logic        o_error,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [10:0] i_cfg_data
);

    logic [10:0]      r_buffer_limit;
    logic [7:0]       r_max_args;
    logic             w_accept;
    clt_pkg::t_op     w_front_op;
    clt_pkg::t_op     w_mid_op;
    logic             w_mid_empty;
    logic             w_out_full;
    logic             w_go;
    clt_pkg::t_result w_back_res;
    clt_pkg::t_result w_out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_limit <= clt_pkg::BUF_LIMIT_RESET;
            r_max_args     <= clt_pkg::MAX_ARGS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                clt_pkg::CFG_BUF_LIMIT: r_buffer_limit <= i_cfg_data;
                clt_pkg::CFG_MAX_ARGS:  r_max_args     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign w_accept = push && !full;
    assign w_go     = !w_mid_empty && !w_out_full;

    clt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_ch          (i_ch),
        .i_end_of_line (i_end_of_line),
        .o_op          (w_front_op)
    );

    clt_fifo #(
        .WIDTH ($bits(clt_pkg::t_op))
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_front_op),
        .o_full  (full),
        .i_pop   (w_go),
        .o_data  (w_mid_op),
        .o_empty (w_mid_empty)
    );

    clt_back #(
        .BUF_DEPTH (BUF_DEPTH),
        .MAX_ARGS  (MAX_ARGS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (w_go),
        .i_op           (w_mid_op),
        .i_buffer_limit (r_buffer_limit),
        .i_max_args     (r_max_args),
        .o_result       (w_back_res)
    );

    clt_fifo #(
        .WIDTH ($bits(clt_pkg::t_result))
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_go),
        .i_data  (w_back_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out_res),
        .o_empty (empty)
    );

    assign o_write_valid = w_out_res.write_valid;
    assign o_write_addr  = w_out_res.write_addr;
    assign o_write_byte  = w_out_res.write_byte;
    assign o_arg_valid   = w_out_res.arg_valid;
    assign o_arg_index   = w_out_res.arg_index;
    assign o_arg_start   = w_out_res.arg_start;
    assign o_done_res    = w_out_res.done_res;
    assign o_arg_total   = w_out_res.arg_total;
    assign o_error       = w_out_res.error;

endmodule

/* design/clt_fifo.sv */
// ----------------------------------------------------------------------------
// Two-entry queue
// Small register queue that decouples the stages; one word may enter and one
// may leave in the same cycle, unless the queue is full.
// ----------------------------------------------------------------------------
module clt_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_do_push;
        n_rd_ptr = r_rd_ptr ^ w_do_pop;
        n_count  = r_count + {1'b0, w_do_push} - {1'b0, w_do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* design/clt_front.sv */
// ----------------------------------------------------------------------------
// Character classifier
// Tracks quote mode and a pending quote, and turns each character into a
// write, an argument close, an end of line or nothing.
// ----------------------------------------------------------------------------
module clt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_ch,
    input  logic          i_end_of_line,
    output clt_pkg::t_op  o_op
);

    logic r_in_quote, n_in_quote;
    logic r_quote_pending, n_quote_pending;

    always_comb begin
        logic quote_now;
        quote_now       = r_in_quote;
        n_in_quote      = r_in_quote;
        n_quote_pending = r_quote_pending;
        o_op.kind       = clt_pkg::OP_NONE;
        o_op.byte_val   = i_ch;

        if (i_end_of_line) begin
            // A quote left pending at the end only flips a mode that is dropped.
            o_op.kind       = clt_pkg::OP_END;
            n_in_quote      = 1'b0;
            n_quote_pending = 1'b0;
        end else if (r_quote_pending && i_ch == clt_pkg::CH_QUOTE) begin
            // Two quotes in a row give one literal quote.
            o_op.kind       = clt_pkg::OP_WRITE;
            n_quote_pending = 1'b0;
        end else begin
            if (r_quote_pending) begin
                quote_now = !r_in_quote;
            end
            n_in_quote      = quote_now;
            n_quote_pending = 1'b0;
            if (i_ch == clt_pkg::CH_SPACE) begin
                o_op.kind = quote_now ? clt_pkg::OP_WRITE : clt_pkg::OP_CLOSE;
            end else if (i_ch == clt_pkg::CH_QUOTE) begin
                n_quote_pending = 1'b1;
            end else begin
                o_op.kind = clt_pkg::OP_WRITE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote      <= 1'b0;
            r_quote_pending <= 1'b0;
        end else if (i_accept) begin
            r_in_quote      <= n_in_quote;
            r_quote_pending <= n_quote_pending;
        end
    end

endmodule

/* design/clt_back.sv */
// ----------------------------------------------------------------------------
// Buffer writer
// Carries out classified operations: keeps the write position, the argument
// start and count, the sticky error, and forms one result word per operation.
// ----------------------------------------------------------------------------
module clt_back #(
    parameter int BUF_DEPTH = 1024,
    parameter int MAX_ARGS  = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  clt_pkg::t_op      i_op,
    input  logic [10:0]       i_buffer_limit,
    input  logic [7:0]        i_max_args,
    output clt_pkg::t_result  o_result
);

    localparam int PW = $clog2(BUF_DEPTH + 1);
    localparam int AW = $clog2(MAX_ARGS + 1);
    localparam int LW = (PW > 11) ? PW : 11;
    localparam int LA = (AW > 8) ? AW : 8;

    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_begin, n_begin;
    logic [AW-1:0] r_count, n_count;
    logic          r_failed, n_failed;
    logic [LW-1:0] w_buf_lim;
    logic [LA-1:0] w_arg_lim;

    always_comb begin
        logic [LW-1:0] cfg_buf;
        logic [LA-1:0] cfg_arg;
        cfg_buf   = LW'(i_buffer_limit);
        cfg_arg   = LA'(i_max_args);
        w_buf_lim = (cfg_buf < LW'(BUF_DEPTH)) ? cfg_buf : LW'(BUF_DEPTH);
        w_arg_lim = (cfg_arg < LA'(MAX_ARGS)) ? cfg_arg : LA'(MAX_ARGS);
    end

    always_comb begin
        logic buf_full;
        buf_full = (LW'(r_pos) >= w_buf_lim);
        n_pos    = r_pos;
        n_begin  = r_begin;
        n_count  = r_count;
        n_failed = r_failed;
        o_result = '0;

        unique case (i_op.kind)
            clt_pkg::OP_WRITE: begin
                if (!r_failed) begin
                    if (buf_full) begin
                        n_failed = 1'b1;
                    end else begin
                        o_result.write_valid = 1'b1;
                        o_result.write_addr  = 10'(r_pos);
                        o_result.write_byte  = i_op.byte_val;
                        n_pos                = r_pos + 1'b1;
                    end
                end
            end
            clt_pkg::OP_CLOSE, clt_pkg::OP_END: begin
                // An empty argument is not closed.
                if (!r_failed && r_pos != r_begin) begin
                    if (LA'(r_count) >= w_arg_lim || buf_full) begin
                        n_failed = 1'b1;
                    end else begin
                        o_result.write_valid = 1'b1;
                        o_result.write_addr  = 10'(r_pos);
                        o_result.write_byte  = 8'd0;
                        o_result.arg_valid   = 1'b1;
                        o_result.arg_index   = 7'(r_count);
                        o_result.arg_start   = 10'(r_begin);
                        n_pos                = r_pos + 1'b1;
                        n_begin              = r_pos + 1'b1;
                        n_count              = r_count + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        o_result.error = n_failed;
        if (i_op.kind == clt_pkg::OP_END) begin
            o_result.done_res  = 1'b1;
            o_result.arg_total = n_failed ? 8'd0 : 8'(n_count);
            n_pos              = '0;
            n_begin            = '0;
            n_count            = '0;
            n_failed           = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_begin  <= '0;
            r_count  <= '0;
            r_failed <= 1'b0;
        end else if (i_go) begin
            r_pos    <= n_pos;
            r_begin  <= n_begin;
            r_count  <= n_count;
            r_failed <= n_failed;
        end
    end

    a_begin_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_begin <= r_pos)
        else $error("argument start is past the write position");

    a_arg_writes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_result.arg_valid) |-> (o_result.write_valid && o_result.write_byte == 8'd0))
        else $error("closed argument without a terminating zero");

    a_write_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_result.write_valid) |-> !o_result.error)
        else $error("byte written while in error");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_op.kind == clt_pkg::OP_END) |=> (r_pos == '0 && r_count == '0 && !r_failed))
        else $error("end of line did not clear the state");

endmodule
